### hw/rtl/crd_pkg.sv
package crd_pkg;

    // Fixed field widths
    localparam int CFG_W   = 9;    // screen_width / screen_height registers
    localparam int COORD_W = 9;    // clamped coordinate, always below 511
    localparam int FIELD_W = 11;   // signed corner fields
    localparam int COLOR_W = 8;

    // Default screen store dimensions
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Reset value of both geometry registers
    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    // Command codes
    typedef enum logic [1:0] {
        MODE_OUTLINE = 2'd0,
        MODE_FILL    = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture an accepted item
        logic setup;        // start address multiply, reset counters
        logic draw_step;    // write one rectangle pixel and advance
        logic clear_step;   // zero one pixel of the screen in use
        logic wipe_step;    // zero one pixel of the whole store
        logic read;         // read one pixel
        logic load_result;  // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  drop;        // rectangle draws nothing
        logic  oor;         // read position outside the screen
        logic  row_end;     // last pixel of the current row
        logic  last_row;    // current row is the bottom one
        logic  clear_last;  // last pixel of a screen clear
        logic  wipe_last;   // last pixel of the store wipe
    } dp_status_t;

endpackage

### hw/rtl/crd_ctrl.sv
module crd_ctrl
    import crd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_WIPE  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SETUP = 7'b0000100,
        ST_DRAW  = 7'b0001000,
        ST_CLEAR = 7'b0010000,
        ST_READ  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_WIPE:
            begin
                cmd.wipe_step = 1'b1;
                if (status.wipe_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup = 1'b1;
                unique case (status.mode)
                    MODE_OUTLINE, MODE_FILL:
                        state_next = status.drop ? ST_DONE : ST_DRAW;
                    MODE_CLEAR:
                        state_next = ST_CLEAR;
                    MODE_READ:
                        state_next = status.oor ? ST_DONE : ST_READ;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_DRAW:
            begin
                cmd.draw_step = 1'b1;
                if (status.row_end && status.last_row)
                    state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                    state_next = ST_DONE;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // output register free or being emptied this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WIPE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a stalled result");

    // An accepted item always goes through the setup cycle
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SETUP)
        else $error("accepted item skipped setup");

    // A drawing command ends in the result state
    a_draw_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && status.row_end && status.last_row)
            |=> state_reg == ST_DONE)
        else $error("draw did not finish");

endmodule

### hw/rtl/crd_datapath.sv
module crd_datapath
    import crd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic [1:0]                mode,
    input  logic signed [FIELD_W-1:0] x_first,
    input  logic signed [FIELD_W-1:0] y_first,
    input  logic signed [FIELD_W-1:0] x_second,
    input  logic signed [FIELD_W-1:0] y_second,
    input  logic [COLOR_W-1:0]        color,
    input  dp_cmd_t                   cmd,
    output dp_status_t                status,
    output logic [COLOR_W-1:0]        pixel_value,
    output logic                      out_of_range
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int PROD_W     = ADDR_W + 1;   // holds width * height itself
    localparam int MUL_W      = 2 * COORD_W;

    // Clamp a signed coordinate to 0..hi
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [FIELD_W-1:0] v,
        input logic [COORD_W-1:0]        hi
    );
        logic [COORD_W-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({2'b00, hi}))
            r = hi;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

    // Geometry registers
    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [COORD_W-1:0] width_use, height_use;
    logic [COORD_W-1:0] width_max, height_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Saturate the registers to 1..MAX
    always_comb
    begin
        if (width_reg == '0)
            width_use = COORD_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            width_use = COORD_W'(MAX_WIDTH);
        else
            width_use = width_reg;
        if (height_reg == '0)
            height_use = COORD_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            height_use = COORD_W'(MAX_HEIGHT);
        else
            height_use = height_reg;
        width_max  = width_use - COORD_W'(1);
        height_max = height_use - COORD_W'(1);
    end

    // Decode of an incoming item
    mode_t              mode_in;
    logic [COORD_W-1:0] cx1, cy1, cx2, cy2;
    logic               neg_second, fill_below, x_rev, y_rev;
    logic               drop_in, oor_in;

    always_comb
    begin
        mode_in    = mode_t'(mode);
        cx1        = clamp_coord(x_first, width_max);
        cy1        = clamp_coord(y_first, height_max);
        cx2        = clamp_coord(x_second, width_max);
        cy2        = clamp_coord(y_second, height_max);
        neg_second = (x_second < 0) || (y_second < 0);
        fill_below = y_first >= $signed({2'b00, height_use});
        x_rev      = cx1 > cx2;
        y_rev      = cy1 > cy2;
        case (mode_in)
            MODE_OUTLINE: drop_in = neg_second;
            MODE_FILL:    drop_in = neg_second || fill_below || x_rev || y_rev;
            default:      drop_in = 1'b0;
        endcase
        oor_in = (x_first < 0) || (x_first >= $signed({2'b00, width_use}))
              || (y_first < 0) || (y_first >= $signed({2'b00, height_use}));
    end

    // Command registers
    mode_t              mode_reg;
    logic               drop_reg, oor_reg;
    logic [COORD_W-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               swap;

    assign swap = (mode_in == MODE_OUTLINE);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode_in;
            drop_reg  <= drop_in;
            oor_reg   <= oor_in;
            color_reg <= color;
            // outline puts its corners in order, fill keeps them
            x_lo_reg  <= (swap && x_rev) ? cx2 : cx1;
            x_hi_reg  <= (swap && x_rev) ? cx1 : cx2;
            y_lo_reg  <= (swap && y_rev) ? cy2 : cy1;
            y_hi_reg  <= (swap && y_rev) ? cy1 : cy2;
        end
    end

    // Row base multiply and pixel walk
    logic [COORD_W-1:0] mul_a;
    logic [MUL_W-1:0]   mul_full;
    logic [PROD_W-1:0]  base_reg;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [ADDR_W-1:0]  sweep_reg;
    logic               full_row;
    logic               row_end, last_row;

    assign mul_a    = (mode_reg == MODE_CLEAR) ? height_use : y_lo_reg;
    assign mul_full = mul_a * width_use;
    assign row_end  = (x_reg == x_hi_reg);
    assign last_row = (y_reg == y_hi_reg);
    assign full_row = (mode_reg == MODE_FILL) || (y_reg == y_lo_reg) || last_row;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            base_reg <= PROD_W'(mul_full);
            x_reg    <= x_lo_reg;
            y_reg    <= y_lo_reg;
        end
        else if (cmd.draw_step)
        begin
            if (row_end)
            begin
                if (!last_row)
                begin
                    y_reg    <= y_reg + COORD_W'(1);
                    base_reg <= base_reg + PROD_W'(width_use);
                    x_reg    <= x_lo_reg;
                end
            end
            else
            begin
                // outline side rows jump straight to the right edge
                x_reg <= full_row ? x_reg + COORD_W'(1) : x_hi_reg;
            end
        end
    end

    // Sweep counter for clear and wipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_reg <= '0;
        else if (cmd.setup)
            sweep_reg <= '0;
        else if (cmd.clear_step || cmd.wipe_step)
            sweep_reg <= sweep_reg + ADDR_W'(1);
    end

    // Frame store, one port
    logic [COLOR_W-1:0] store_mem [STORE_SIZE];
    logic [COLOR_W-1:0] rd_data_reg;
    logic [PROD_W-1:0]  pix_addr;
    logic [ADDR_W-1:0]  mem_addr;
    logic               mem_we;
    logic [COLOR_W-1:0] mem_wdata;

    assign pix_addr  = base_reg + PROD_W'(x_reg);
    assign mem_addr  = (cmd.clear_step || cmd.wipe_step) ? sweep_reg
                                                         : pix_addr[ADDR_W-1:0];
    assign mem_we    = cmd.draw_step || cmd.clear_step || cmd.wipe_step;
    assign mem_wdata = cmd.draw_step ? color_reg : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
        if (cmd.read)
            rd_data_reg <= store_mem[mem_addr];
    end

    // Output register
    logic [COLOR_W-1:0] pixel_reg;
    logic               oor_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            pixel_reg   <= (mode_reg == MODE_READ && !oor_reg) ? rd_data_reg : '0;
            oor_out_reg <= (mode_reg == MODE_READ) && oor_reg;
        end
    end

    assign pixel_value  = pixel_reg;
    assign out_of_range = oor_out_reg;

    // Status
    always_comb
    begin
        status            = '0;
        status.mode       = mode_reg;
        status.drop       = drop_reg;
        status.oor        = oor_reg;
        status.row_end    = row_end;
        status.last_row   = last_row;
        status.clear_last = ({1'b0, sweep_reg} == (base_reg - PROD_W'(1)));
        status.wipe_last  = (sweep_reg == ADDR_W'(STORE_SIZE - 1));
    end

    // The walker stays inside the rectangle
    a_walk_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_step |-> (x_reg >= x_lo_reg && x_reg <= x_hi_reg
                           && y_reg >= y_lo_reg && y_reg <= y_hi_reg))
        else $error("pixel walker left the rectangle");

    // Drawn pixels lie on the screen in use
    a_walk_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_step |-> (x_reg < width_use && y_reg < height_use))
        else $error("drawn pixel off screen");

    // Within a row the column only moves right
    a_walk_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.draw_step && !row_end) |=> x_reg > $past(x_reg))
        else $error("column did not advance");

endmodule

### hw/rtl/clipped_rectangle_draw_core.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  mode, x_first, y_first, x_second, y_second, color
// out      out_valid/ out_stall pixel_value, out_of_range
// cfg      cfg_we               cfg_index, cfg_data (no stall)
//
// After reset all MAX_WIDTH * MAX_HEIGHT pixels (65536 by default) of the frame store
// are zeroed, one pixel a cycle, with the input stalled; config writes still land.
// An item writes its pixels one per cycle: fill (dx+1)*(dy+1), outline its
// perimeter, clear width*height; a read reads one pixel, and a dropped rectangle
// or an out-of-range read writes and reads nothing. The single frame store port
// sets this, one pixel per cycle.
// The next item is taken while an earlier result waits in the output register.
module clipped_rectangle_draw_core
    import crd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                mode,
    input  logic signed [FIELD_W-1:0] x_first,
    input  logic signed [FIELD_W-1:0] y_first,
    input  logic signed [FIELD_W-1:0] x_second,
    input  logic signed [FIELD_W-1:0] y_second,
    input  logic [COLOR_W-1:0]        color,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [COLOR_W-1:0]        pixel_value,
    output logic                      out_of_range
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    crd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Geometry, pixel walker and frame store
    crd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .x_first      (x_first),
        .y_first      (y_first),
        .x_second     (x_second),
        .y_second     (y_second),
        .color        (color),
        .cmd          (cmd),
        .status       (status),
        .pixel_value  (pixel_value),
        .out_of_range (out_of_range)
    );

endmodule
